// File: design/cos_pkg.sv
// types, widths and codes shared by the circle overlap separation block
`default_nettype none

package cos_pkg;

  localparam int unsigned POS_W    = 24;
  localparam int unsigned RAD_W    = 20;
  localparam int unsigned MASS_W   = 24;
  localparam int unsigned DIFF_W   = POS_W + 1;
  localparam int unsigned SQ_W     = 2 * POS_W + 1;
  localparam int unsigned D2_W     = SQ_W + 1;
  localparam int unsigned DIST_W   = D2_W / 2;
  localparam int unsigned SUM_W    = RAD_W + 1;
  localparam int unsigned NUM_T_W  = 2 * SUM_W;
  localparam int unsigned WT_W     = MASS_W + 1;
  localparam int unsigned NUM_P_W  = SUM_W + MASS_W;
  localparam int unsigned EXT_W    = POS_W + 2;

  localparam logic signed [POS_W-1:0] PosMax = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] PosMin = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic [1:0] {
    COS_NONE       = 2'd0,
    COS_SEPARATED  = 2'd1,
    COS_COINCIDENT = 2'd2
  } cos_status_e;

  typedef struct packed {
    logic signed [POS_W-1:0] a_pos_x;
    logic signed [POS_W-1:0] a_pos_y;
    logic [RAD_W-1:0]        a_radius;
    logic [MASS_W-1:0]       a_mass;
    logic signed [POS_W-1:0] b_pos_x;
    logic signed [POS_W-1:0] b_pos_y;
    logic [RAD_W-1:0]        b_radius;
    logic [MASS_W-1:0]       b_mass;
  } cos_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_a_x;
    logic signed [POS_W-1:0] new_a_y;
    logic signed [POS_W-1:0] new_b_x;
    logic signed [POS_W-1:0] new_b_y;
    logic [1:0]              contact_status;
  } cos_out_t;

  typedef struct packed {
    logic signed [POS_W-1:0] ax;
    logic signed [POS_W-1:0] ay;
    logic signed [POS_W-1:0] bx;
    logic signed [POS_W-1:0] by;
  } cos_pos_t;

  // travels alongside the square root
  typedef struct packed {
    cos_pos_t          pos;
    logic [SUM_W-1:0]  rsum;
    logic [MASS_W-1:0] am;
    logic [MASS_W-1:0] bm;
    logic [SUM_W-1:0]  mag_x;
    logic [SUM_W-1:0]  mag_y;
    logic              neg_x;
    logic              neg_y;
    logic              d2_zero;
  } cos_pre_t;

  // travels alongside the direction divide
  typedef struct packed {
    cos_pos_t          pos;
    logic              neg_x;
    logic              neg_y;
    cos_status_e       status;
    logic [MASS_W-1:0] wa;
    logic [MASS_W-1:0] wb;
    logic [WT_W-1:0]   wt;
  } cos_mid_t;

  // travels alongside the mass divide
  typedef struct packed {
    cos_pos_t    pos;
    logic        neg_x;
    logic        neg_y;
    cos_status_e status;
  } cos_post_t;

endpackage

`default_nettype wire

// File: design/cos_sqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none

module cos_sqrt #(
  parameter int unsigned RAD_W = 50,
  parameter int unsigned SB_W  = 1,
  localparam int unsigned ROOT_W = RAD_W / 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [RAD_W-1:0]  rad_i,
  input  wire logic [SB_W-1:0]   sb_i,
  output logic                   valid_o,
  output logic [ROOT_W-1:0]      root_o,
  output logic [SB_W-1:0]        sb_o
);

  localparam int unsigned REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [SB_W-1:0]   sb_q   [ROOT_W];
  logic              vld_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SB_W-1:0]   sb_in;
    logic              vld_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign sb_in   = sb_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign sb_in   = sb_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // bring down the next two radicand bits, try 4*root+1
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
        rad_q[k]  <= rad_in << 2;
        sb_q[k]   <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign sb_o    = sb_q[ROOT_W-1];

endmodule

`default_nettype wire

// File: design/cos_div.sv
// pipelined restoring divider, several lanes over one shared divisor
`default_nettype none

module cos_div #(
  parameter int unsigned NUM_W = 42,
  parameter int unsigned DEN_W = 21,
  parameter int unsigned QUO_W = 21,
  parameter int unsigned LANES = 2,
  parameter int unsigned SB_W  = 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [LANES-1:0][NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0]            den_i,
  input  wire logic [SB_W-1:0]             sb_i,
  output logic                             valid_o,
  output logic [LANES-1:0][QUO_W-1:0]      quo_o,
  output logic [SB_W-1:0]                  sb_o
);

  localparam int unsigned CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [LANES-1:0][CW-1:0]    rem_q [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] quo_q [QUO_W];
  logic [DEN_W-1:0]            den_q [QUO_W];
  logic [SB_W-1:0]             sb_q  [QUO_W];
  logic                        vld_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int unsigned SH = QUO_W - 1 - k;

    logic [LANES-1:0][CW-1:0]    rem_in;
    logic [LANES-1:0][CW-1:0]    rem_nx;
    logic [LANES-1:0][QUO_W-1:0] quo_in;
    logic [LANES-1:0][QUO_W-1:0] quo_nx;
    logic [DEN_W-1:0]            den_in;
    logic [SB_W-1:0]             sb_in;
    logic                        vld_in;
    logic [CW-1:0]               sd;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_ld
        assign rem_in[l] = CW'(num_i[l]);
        assign quo_in[l] = '0;
      end
      assign den_in = den_i;
      assign sb_in  = sb_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign sb_in  = sb_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    assign sd = CW'(den_in) << SH;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic ge;
      assign ge        = rem_in[l] >= sd;
      assign rem_nx[l] = ge ? rem_in[l] - sd : rem_in[l];
      assign quo_nx[l] = {quo_in[l][QUO_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_nx;
        quo_q[k] <= quo_nx;
        den_q[k] <= den_in;
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign sb_o    = sb_q[QUO_W-1];

endmodule

`default_nettype wire

// File: design/circle_overlap_separation.sv
// top level: mass-weighted overlap separation of two circles
//
//  channel  signals                           direction
//  in       in_valid_i in_ready_o in_item_i   one circle pair
//  out      out_valid_o out_ready_i out_item_o  resolved centres and status
//
// one pair enters per cycle while the output is not stalled; each item passes
// through differences and squares, square root, overlap, direction divide,
// weighting, mass divide and the output register, in that order
// the whole pipeline holds while a result waits, so in_ready_o follows the
// output register: high when it is empty or being taken
// reset clears the valid bits only; the data registers are not reset
`default_nettype none

module circle_overlap_separation
  import cos_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire cos_in_t  in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output cos_out_t      out_item_o
);

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [EXT_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > EXT_W'(PosMax)) begin
      r = PosMax;
    end else if (v < EXT_W'(PosMin)) begin
      r = PosMin;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  logic en;

  // stage 1: input register
  cos_in_t in1_q;
  logic    v1_q;

  // stage 2: differences
  cos_in_t           in2_q;
  logic [DIFF_W-1:0] magx2_q, magy2_q;
  logic              negx2_q, negy2_q;
  logic              v2_q;
  logic signed [DIFF_W-1:0] dx, dy;

  // stage 3: squares
  cos_in_t           in3_q;
  logic [DIFF_W-1:0] magx3_q, magy3_q;
  logic              negx3_q, negy3_q;
  logic [SQ_W-1:0]   sqx3_q, sqy3_q;
  logic              v3_q;
  logic [2*DIFF_W-1:0] prodx, prody;

  // stage 4: sum of squares
  logic [D2_W-1:0] d2_4_q;
  cos_pre_t        pre4_q, pre4_d;
  logic            v4_q;

  // square root
  logic              vs;
  logic [DIST_W-1:0] dist_s;
  cos_pre_t          pre_s;

  // stage 5: overlap and weights
  logic [SUM_W-1:0] ov5_q, dist5_q, magx5_q, magy5_q;
  cos_mid_t         mid5_q, mid5_d;
  logic             v5_q;
  logic [SUM_W-1:0] ov5_d;
  logic [WT_W-1:0]  wt_raw;

  // stage 6: direction numerators
  logic [1:0][NUM_T_W-1:0] num6_q;
  logic [SUM_W-1:0]        dist6_q;
  cos_mid_t                mid6_q;
  logic                    v6_q;

  // direction divide
  logic                  vt;
  logic [1:0][SUM_W-1:0] t_s;
  cos_mid_t              mid_s;

  // stage 7: mass numerators
  logic [3:0][NUM_P_W-1:0] num7_q, num7_d;
  logic [WT_W-1:0]         wt7_q;
  cos_post_t               post7_q, post7_d;
  logic                    v7_q;

  // mass divide
  logic                  vp;
  logic [3:0][SUM_W-1:0] push_s;
  cos_post_t             post_s;

  // stage 8: output register
  cos_out_t out_q, out_d;
  logic     out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= vs;
      v6_q        <= v5_q;
      v7_q        <= vt;
      out_valid_q <= vp;
    end
  end

  assign dx = DIFF_W'(in1_q.b_pos_x) - DIFF_W'(in1_q.a_pos_x);
  assign dy = DIFF_W'(in1_q.b_pos_y) - DIFF_W'(in1_q.a_pos_y);

  assign prodx = magx2_q * magx2_q;
  assign prody = magy2_q * magy2_q;

  always_comb begin
    pre4_d.pos.ax  = in3_q.a_pos_x;
    pre4_d.pos.ay  = in3_q.a_pos_y;
    pre4_d.pos.bx  = in3_q.b_pos_x;
    pre4_d.pos.by  = in3_q.b_pos_y;
    pre4_d.rsum    = SUM_W'(in3_q.a_radius) + SUM_W'(in3_q.b_radius);
    pre4_d.am      = in3_q.a_mass;
    pre4_d.bm      = in3_q.b_mass;
    // only read when overlapping, where the distance fits the radius sum
    pre4_d.mag_x   = magx3_q[SUM_W-1:0];
    pre4_d.mag_y   = magy3_q[SUM_W-1:0];
    pre4_d.neg_x   = negx3_q;
    pre4_d.neg_y   = negy3_q;
    pre4_d.d2_zero = (magx3_q == '0) && (magy3_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in1_q   <= in_item_i;
      in2_q   <= in1_q;
      magx2_q <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      magy2_q <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
      negx2_q <= dx[DIFF_W-1];
      negy2_q <= dy[DIFF_W-1];
      in3_q   <= in2_q;
      magx3_q <= magx2_q;
      magy3_q <= magy2_q;
      negx3_q <= negx2_q;
      negy3_q <= negy2_q;
      sqx3_q  <= prodx[SQ_W-1:0];
      sqy3_q  <= prody[SQ_W-1:0];
      d2_4_q  <= D2_W'(sqx3_q) + D2_W'(sqy3_q);
      pre4_q  <= pre4_d;
    end
  end

  cos_sqrt #(
    .RAD_W (D2_W),
    .SB_W  ($bits(cos_pre_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .rad_i   (d2_4_q),
    .sb_i    (pre4_q),
    .valid_o (vs),
    .root_o  (dist_s),
    .sb_o    (pre_s)
  );

  assign wt_raw = WT_W'(pre_s.am) + WT_W'(pre_s.bm);
  assign ov5_d  = pre_s.rsum - dist_s[SUM_W-1:0];

  always_comb begin
    mid5_d.pos   = pre_s.pos;
    mid5_d.neg_x = pre_s.neg_x;
    mid5_d.neg_y = pre_s.neg_y;
    if (dist_s >= DIST_W'(pre_s.rsum)) begin
      mid5_d.status = COS_NONE;
    end else if (pre_s.d2_zero) begin
      mid5_d.status = COS_COINCIDENT;
    end else begin
      mid5_d.status = COS_SEPARATED;
    end
    // two massless circles share the push equally
    if (wt_raw == '0) begin
      mid5_d.wa = MASS_W'(1);
      mid5_d.wb = MASS_W'(1);
      mid5_d.wt = WT_W'(2);
    end else begin
      mid5_d.wa = pre_s.am;
      mid5_d.wb = pre_s.bm;
      mid5_d.wt = wt_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ov5_q     <= ov5_d;
      dist5_q   <= dist_s[SUM_W-1:0];
      magx5_q   <= pre_s.mag_x;
      magy5_q   <= pre_s.mag_y;
      mid5_q    <= mid5_d;
      num6_q[0] <= NUM_T_W'(magx5_q * ov5_q) + NUM_T_W'(dist5_q >> 1);
      num6_q[1] <= NUM_T_W'(magy5_q * ov5_q) + NUM_T_W'(dist5_q >> 1);
      dist6_q   <= dist5_q;
      mid6_q    <= mid5_q;
    end
  end

  cos_div #(
    .NUM_W (NUM_T_W),
    .DEN_W (SUM_W),
    .QUO_W (SUM_W),
    .LANES (2),
    .SB_W  ($bits(cos_mid_t))
  ) u_dir_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .num_i   (num6_q),
    .den_i   (dist6_q),
    .sb_i    (mid6_q),
    .valid_o (vt),
    .quo_o   (t_s),
    .sb_o    (mid_s)
  );

  always_comb begin
    num7_d[0]      = NUM_P_W'(t_s[0] * mid_s.wb) + NUM_P_W'(mid_s.wt >> 1);
    num7_d[1]      = NUM_P_W'(t_s[1] * mid_s.wb) + NUM_P_W'(mid_s.wt >> 1);
    num7_d[2]      = NUM_P_W'(t_s[0] * mid_s.wa) + NUM_P_W'(mid_s.wt >> 1);
    num7_d[3]      = NUM_P_W'(t_s[1] * mid_s.wa) + NUM_P_W'(mid_s.wt >> 1);
    post7_d.pos    = mid_s.pos;
    post7_d.neg_x  = mid_s.neg_x;
    post7_d.neg_y  = mid_s.neg_y;
    post7_d.status = mid_s.status;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num7_q  <= num7_d;
      wt7_q   <= mid_s.wt;
      post7_q <= post7_d;
    end
  end

  cos_div #(
    .NUM_W (NUM_P_W),
    .DEN_W (WT_W),
    .QUO_W (SUM_W),
    .LANES (4),
    .SB_W  ($bits(cos_post_t))
  ) u_mass_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (num7_q),
    .den_i   (wt7_q),
    .sb_i    (post7_q),
    .valid_o (vp),
    .quo_o   (push_s),
    .sb_o    (post_s)
  );

  always_comb begin
    logic signed [EXT_W-1:0] pax, pay, pbx, pby;
    pax = signed'(EXT_W'(push_s[0]));
    pay = signed'(EXT_W'(push_s[1]));
    pbx = signed'(EXT_W'(push_s[2]));
    pby = signed'(EXT_W'(push_s[3]));
    out_d.contact_status = post_s.status;
    if (post_s.status == COS_SEPARATED) begin
      // a moves against the centre line, b along it
      out_d.new_a_x = sat_pos(post_s.neg_x ? EXT_W'(post_s.pos.ax) + pax
                                           : EXT_W'(post_s.pos.ax) - pax);
      out_d.new_a_y = sat_pos(post_s.neg_y ? EXT_W'(post_s.pos.ay) + pay
                                           : EXT_W'(post_s.pos.ay) - pay);
      out_d.new_b_x = sat_pos(post_s.neg_x ? EXT_W'(post_s.pos.bx) - pbx
                                           : EXT_W'(post_s.pos.bx) + pbx);
      out_d.new_b_y = sat_pos(post_s.neg_y ? EXT_W'(post_s.pos.by) - pby
                                           : EXT_W'(post_s.pos.by) + pby);
    end else begin
      out_d.new_a_x = post_s.pos.ax;
      out_d.new_a_y = post_s.pos.ay;
      out_d.new_b_x = post_s.pos.bx;
      out_d.new_b_y = post_s.pos.by;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: design/cos_checker.sv
// port checks for the circle overlap separation block
`default_nettype none

module cos_checker
  import cos_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire cos_in_t  in_item_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire cos_out_t out_item_o
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item dropped or changed while stalled");

  // the pipeline never refuses input while the output drains
  a_ready_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input refused while output is taken");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input refused with an empty output register");

  // the contact status of a result is never the undefined code 3
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.contact_status != 2'd3)
    else $error("undefined contact status");

  // a new result appears only after the pipeline advanced, never out of a stall
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("result appeared during a stall");

endmodule

bind circle_overlap_separation cos_checker u_cos_checker (.*);

`default_nettype wire
